@@ src/scaf_pkg.sv @@
// Shared types, constants and the scancode translation table.
`timescale 1ns / 1ps
package scaf_pkg;

  localparam int unsigned QueueDepthDflt = 256;

  localparam int unsigned ScW   = 8;
  localparam int unsigned CharW = 7;

  localparam logic OpScan = 1'b0;
  localparam logic OpRead = 1'b1;

  localparam logic [ScW-1:0] ScRelBit = 8'h80;
  localparam logic [ScW-1:0] ScLshift = 8'h2A;
  localparam logic [ScW-1:0] ScRshift = 8'h36;

  typedef struct packed {
    logic load;    // capture request, launch queue read
    logic commit;  // apply request, load result register
  } scaf_cmd_t;

  typedef struct packed {
    logic out_free;  // result register empty or being taken
  } scaf_sts_t;

  // US layout, set-1 make codes; zero means no character
  function automatic logic [CharW-1:0] scaf_map(input logic [6:0] idx, input logic shift);
    logic [7:0] pl;
    logic [7:0] sh;
    pl = 8'h00;
    sh = 8'h00;
    case (idx)
      7'h02: begin pl = "1"; sh = "!"; end
      7'h03: begin pl = "2"; sh = "@"; end
      7'h04: begin pl = "3"; sh = "#"; end
      7'h05: begin pl = "4"; sh = "$"; end
      7'h06: begin pl = "5"; sh = "%"; end
      7'h07: begin pl = "6"; sh = "^"; end
      7'h08: begin pl = "7"; sh = "&"; end
      7'h09: begin pl = "8"; sh = "*"; end
      7'h0A: begin pl = "9"; sh = "("; end
      7'h0B: begin pl = "0"; sh = ")"; end
      7'h0C: begin pl = "-"; sh = "_"; end
      7'h0D: begin pl = "="; sh = "+"; end
      7'h0E: begin pl = 8'h08; sh = 8'h08; end
      7'h10: begin pl = "q"; sh = "Q"; end
      7'h11: begin pl = "w"; sh = "W"; end
      7'h12: begin pl = "e"; sh = "E"; end
      7'h13: begin pl = "r"; sh = "R"; end
      7'h14: begin pl = "t"; sh = "T"; end
      7'h15: begin pl = "y"; sh = "Y"; end
      7'h16: begin pl = "u"; sh = "U"; end
      7'h17: begin pl = "i"; sh = "I"; end
      7'h18: begin pl = "o"; sh = "O"; end
      7'h19: begin pl = "p"; sh = "P"; end
      7'h1A: begin pl = "["; sh = "{"; end
      7'h1B: begin pl = "]"; sh = "}"; end
      7'h1C: begin pl = 8'h0A; sh = 8'h0A; end
      7'h1E: begin pl = "a"; sh = "A"; end
      7'h1F: begin pl = "s"; sh = "S"; end
      7'h20: begin pl = "d"; sh = "D"; end
      7'h21: begin pl = "f"; sh = "F"; end
      7'h22: begin pl = "g"; sh = "G"; end
      7'h23: begin pl = "h"; sh = "H"; end
      7'h24: begin pl = "j"; sh = "J"; end
      7'h25: begin pl = "k"; sh = "K"; end
      7'h26: begin pl = "l"; sh = "L"; end
      7'h27: begin pl = ";"; sh = ":"; end
      7'h28: begin pl = 8'h27; sh = 8'h22; end
      7'h2B: begin pl = 8'h5C; sh = "|"; end
      7'h2C: begin pl = "z"; sh = "Z"; end
      7'h2D: begin pl = "x"; sh = "X"; end
      7'h2E: begin pl = "c"; sh = "C"; end
      7'h2F: begin pl = "v"; sh = "V"; end
      7'h30: begin pl = "b"; sh = "B"; end
      7'h31: begin pl = "n"; sh = "N"; end
      7'h32: begin pl = "m"; sh = "M"; end
      7'h33: begin pl = ","; sh = "<"; end
      7'h34: begin pl = "."; sh = ">"; end
      7'h35: begin pl = "/"; sh = "?"; end
      7'h39: begin pl = " "; sh = " "; end
      default: begin pl = 8'h00; sh = 8'h00; end
    endcase
    return shift ? sh[CharW-1:0] : pl[CharW-1:0];
  endfunction

endpackage

@@ src/scaf_if.sv @@
// Request and response channel interfaces.
`timescale 1ns / 1ps
interface scaf_req_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] scancode;

  modport source (output valid, output op, output scancode, input ready);
  modport sink (input valid, input op, input scancode, output ready);
endinterface

interface scaf_rsp_if;
  logic       valid;
  logic       ready;
  logic       char_valid;
  logic [6:0] character;
  logic       has_char;
  logic       dropped;

  modport source (output valid, output char_valid, output character, output has_char,
                  output dropped, input ready);
  modport sink (input valid, input char_valid, input character, input has_char,
                input dropped, output ready);
endinterface

@@ src/scaf_ctrl.sv @@
// Controller: capture a request, then commit it into the result register.
`timescale 1ns / 1ps
module scaf_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  scaf_pkg::scaf_sts_t sts_i,
  output scaf_pkg::scaf_cmd_t cmd_o
);
  import scaf_pkg::*;

  localparam logic StIdle = 1'b0;
  localparam logic StExec = 1'b1;

  logic state_q;
  logic state_d;

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StExec;
        end
      end
      StExec: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end
endmodule

@@ src/scaf_dp.sv @@
// Datapath: request registers, translation, shift flag, character queue, result register.
`timescale 1ns / 1ps
module scaf_dp #(
  parameter int unsigned QUEUE_DEPTH = scaf_pkg::QueueDepthDflt
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         op_i,
  input  logic [scaf_pkg::ScW-1:0]     scancode_i,
  input  scaf_pkg::scaf_cmd_t          cmd_i,
  output scaf_pkg::scaf_sts_t          sts_o,
  scaf_rsp_if.source                   rsp_o
);
  import scaf_pkg::*;

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(QUEUE_DEPTH - 1);

  logic             op_q;
  logic [ScW-1:0]   sc_q;
  logic [CharW-1:0] rdata_q;
  logic [CharW-1:0] mem_q [QUEUE_DEPTH];

  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic             shift_q, shift_d;

  logic             out_vld_q;
  logic             char_vld_q, char_vld_d;
  logic [CharW-1:0] char_q, char_d;
  logic             has_char_q;
  logic             drop_q, drop_d;

  logic [PtrW-1:0]  wr_nxt, rd_nxt;
  logic [CharW-1:0] map_ch;
  logic             wr_en;

  assign wr_nxt = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
  assign rd_nxt = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
  assign map_ch = scaf_map(sc_q[6:0], shift_q);

  always_comb begin
    wr_ptr_d   = wr_ptr_q;
    rd_ptr_d   = rd_ptr_q;
    shift_d    = shift_q;
    char_vld_d = 1'b0;
    char_d     = '0;
    drop_d     = 1'b0;
    wr_en      = 1'b0;
    if (op_q == OpRead) begin
      if (wr_ptr_q != rd_ptr_q) begin
        char_vld_d = 1'b1;
        char_d     = rdata_q;
        rd_ptr_d   = rd_nxt;
      end
    end else if (sc_q == ScLshift || sc_q == ScRshift) begin
      shift_d = 1'b1;
    end else if (sc_q == (ScLshift | ScRelBit) || sc_q == (ScRshift | ScRelBit)) begin
      shift_d = 1'b0;
    end else if ((sc_q & ScRelBit) == '0 && map_ch != '0) begin
      if (wr_nxt == rd_ptr_q) begin
        drop_d = 1'b1;
      end else begin
        wr_en    = 1'b1;
        wr_ptr_d = wr_nxt;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && wr_en) begin
      mem_q[wr_ptr_q] <= map_ch;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= op_i;
      sc_q    <= scancode_i;
      rdata_q <= mem_q[rd_ptr_q];
    end
    if (cmd_i.commit) begin
      char_vld_q <= char_vld_d;
      char_q     <= char_d;
      has_char_q <= (wr_ptr_d != rd_ptr_d);
      drop_q     <= drop_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q  <= '0;
      rd_ptr_q  <= '0;
      shift_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (cmd_i.commit) begin
        wr_ptr_q  <= wr_ptr_d;
        rd_ptr_q  <= rd_ptr_d;
        shift_q   <= shift_d;
        out_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign sts_o.out_free  = !out_vld_q || rsp_o.ready;

  assign rsp_o.valid      = out_vld_q;
  assign rsp_o.char_valid = char_vld_q;
  assign rsp_o.character  = char_q;
  assign rsp_o.has_char   = has_char_q;
  assign rsp_o.dropped    = drop_q;
endmodule

@@ src/scancode_to_ascii_fifo.sv @@
// Set-1 scancode to US-layout ASCII translator with a character queue.
//
// Usage:
//   req_i carries one request: op = 0 delivers a scancode byte, op = 1 reads
//   one character. Every request produces exactly one response on rsp_o with
//   char_valid/character (read result), has_char (queue non-empty afterward)
//   and dropped (a decoded character was lost on a full queue).
//   Shift make/break codes update the held-shift flag; other break codes and
//   unmapped make codes leave the queue untouched.
//   An accepted request is captured together with a read of the queue memory
//   port; it is then applied and its result loaded into the output register
//   once that register is free. A new request is not accepted until the
//   previous one has been applied.
//   The queue holds QUEUE_DEPTH-1 characters.
//   A finished response waits in an output register; the next request is
//   accepted meanwhile, and its commit waits until rsp_o.ready frees the
//   register.
//   Reset empties the queue, clears the shift flag and drops any pending
//   response; no clearing pass is needed.
`timescale 1ns / 1ps
module scancode_to_ascii_fifo #(
  parameter int unsigned QUEUE_DEPTH = scaf_pkg::QueueDepthDflt
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  scaf_req_if.sink   req_i,
  scaf_rsp_if.source rsp_o
);
  import scaf_pkg::*;

  scaf_cmd_t cmd;
  scaf_sts_t sts;
  logic      in_ready;

  assign req_i.ready = in_ready;

  scaf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  scaf_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_i       (req_i.op),
    .scancode_i (req_i.scancode),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .rsp_o      (rsp_o)
  );

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && in_ready) |=> !in_ready)
    else $error("request accepted while previous one still in progress");

  a_commit_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> sts.out_free)
    else $error("result register overwritten before it was taken");

  a_popped_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.char_valid) |-> rsp_o.character != '0)
    else $error("popped a character that was never queued");

  a_drop_means_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.dropped) |-> (rsp_o.has_char && !rsp_o.char_valid))
    else $error("drop reported without a full queue");
`endif
endmodule

@@ tb/scancode_to_ascii_fifo_tb.sv @@
// Self-checking testbench for the scancode translator and its character queue.
`timescale 1ns / 1ps
module scancode_to_ascii_fifo_tb;
  import scaf_pkg::*;

  localparam logic [ScW-1:0] ScBackspace = 8'h0E;
  localparam logic [ScW-1:0] ScEnter     = 8'h1C;
  localparam logic [ScW-1:0] ScSpace     = 8'h39;
  localparam logic [ScW-1:0] ScPipe      = 8'h2B;

  typedef struct packed {
    logic             char_valid;
    logic [CharW-1:0] character;
    logic             has_char;
    logic             dropped;
  } char_rsp_t;

  typedef enum int {TrafficMix, TrafficFill, TrafficDrain} traffic_e;
  typedef enum int {RdyAlways, RdyCoin, RdySparse, RdyMostly} ready_mode_e;

  class char_fifo_scoreboard;
    logic [CharW-1:0] held_chars[$];
    char_rsp_t        expected_rsp[$];
    logic             shift_down;
    int unsigned      mismatches;

    function new();
      shift_down = 1'b0;
      mismatches = 0;
    endfunction

    // US layout translation, zero when the make code has no character
    function logic [CharW-1:0] map_char(logic [6:0] idx, logic shift);
      string num_p = "1234567890-=";
      string num_s = "!@#$%^&*()_+";
      string top_p = "qwertyuiop[]";
      string top_s = "QWERTYUIOP{}";
      string mid_p = "asdfghjkl;'";
      string mid_s = "ASDFGHJKL:\"";
      string bot_p = "zxcvbnm,./";
      string bot_s = "ZXCVBNM<>?";
      byte   ch;
      int    i;
      ch = 8'h00;
      i = idx;
      if (idx == ScBackspace[6:0]) ch = 8'h08;
      else if (idx == ScEnter[6:0]) ch = 8'h0A;
      else if (idx == ScSpace[6:0]) ch = " ";
      else if (idx == ScPipe[6:0]) ch = shift ? "|" : "\\";
      else if (i >= 'h02 && i <= 'h0D) ch = shift ? num_s[i - 'h02] : num_p[i - 'h02];
      else if (i >= 'h10 && i <= 'h1B) ch = shift ? top_s[i - 'h10] : top_p[i - 'h10];
      else if (i >= 'h1E && i <= 'h28) ch = shift ? mid_s[i - 'h1E] : mid_p[i - 'h1E];
      else if (i >= 'h2C && i <= 'h35) ch = shift ? bot_s[i - 'h2C] : bot_p[i - 'h2C];
      return ch[CharW-1:0];
    endfunction

    function void note_request(logic op, logic [ScW-1:0] sc);
      char_rsp_t        r;
      logic [CharW-1:0] c;
      r = '0;
      if (op == OpRead) begin
        if (held_chars.size() != 0) begin
          r.char_valid = 1'b1;
          r.character  = held_chars.pop_front();
        end
      end else if (sc == ScLshift || sc == ScRshift) begin
        shift_down = 1'b1;
      end else if (sc == (ScLshift | ScRelBit) || sc == (ScRshift | ScRelBit)) begin
        shift_down = 1'b0;
      end else if ((sc & ScRelBit) == '0) begin
        c = map_char(sc[6:0], shift_down);
        if (c != '0) begin
          if (held_chars.size() == QueueDepthDflt - 1) r.dropped = 1'b1;
          else held_chars.push_back(c);
        end
      end
      r.has_char = (held_chars.size() != 0);
      expected_rsp.push_back(r);
    endfunction

    function void compare_field(string name, logic [CharW-1:0] exp, logic [CharW-1:0] act);
      if (act !== exp) begin
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp, act);
        mismatches++;
      end
    endfunction

    function void check_response(char_rsp_t got);
      char_rsp_t exp;
      if (expected_rsp.size() == 0) begin
        $display("%0t: response with none expected, actual %0h", $time, got);
        mismatches++;
        return;
      end
      exp = expected_rsp.pop_front();
      compare_field("char_valid", exp.char_valid, got.char_valid);
      compare_field("character", exp.character, got.character);
      compare_field("has_char", exp.has_char, got.has_char);
      compare_field("dropped", exp.dropped, got.dropped);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        stall_ready = 1'b0;
  logic        req_up;
  int          items_sent;
  int          burst_left;
  int unsigned rdy_cycle = 0;
  ready_mode_e rdy_mode = RdyAlways;

  char_fifo_scoreboard sb;

  scaf_req_if req_if ();
  scaf_rsp_if rsp_if ();

  assign rsp_if.ready = stall_ready;

  scancode_to_ascii_fifo u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    rdy_cycle <= rdy_cycle + 1;
    if (rdy_cycle % 97 == 0) rdy_mode <= ready_mode_e'($urandom_range(0, 3));
    if (!rst_n) begin
      stall_ready <= 1'b0;
    end else begin
      case (rdy_mode)
        RdyAlways: stall_ready <= 1'b1;
        RdyCoin:   stall_ready <= 1'($urandom_range(0, 1));
        RdySparse: stall_ready <= (rdy_cycle % 4 == 0);
        default:   stall_ready <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && rsp_if.valid && rsp_if.ready)
      sb.check_response({rsp_if.char_valid, rsp_if.character, rsp_if.has_char,
                         rsp_if.dropped});
  end

  task automatic send_request(input logic op, input logic [ScW-1:0] sc);
    req_if.valid    <= 1'b1;
    req_if.op       <= op;
    req_if.scancode <= sc;
    req_up = 1'b1;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    sb.note_request(op, sc);
    items_sent++;
  endtask

  task automatic issue(input logic op, input logic [ScW-1:0] sc);
    int gap;
    send_request(op, sc);
    burst_left--;
    if (burst_left <= 0) begin
      gap = $urandom_range(0, 6);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
      if (gap != 0) begin
        req_if.valid <= 1'b0;
        req_up = 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  function automatic logic [ScW-1:0] pick_key();
    logic [ScW-1:0] code;
    do code = 8'($urandom_range(8'h02, 8'h39));
    while (sb.map_char(code[6:0], 1'b0) == '0);
    return code;
  endfunction

  // optional shift press, one to six keys with optional releases, shift release (sometimes missing)
  task automatic type_word();
    int             n;
    logic           shifted;
    logic [ScW-1:0] key;
    shifted = ($urandom_range(0, 2) == 0);
    n = $urandom_range(1, 6);
    if (shifted) issue(OpScan, ($urandom_range(0, 1) != 0) ? ScLshift : ScRshift);
    repeat (n) begin
      key = pick_key();
      issue(OpScan, key);
      if ($urandom_range(0, 1) != 0) issue(OpScan, key | ScRelBit);
    end
    if (shifted && $urandom_range(0, 4) != 0)
      issue(OpScan, (($urandom_range(0, 1) != 0) ? ScLshift : ScRshift) | ScRelBit);
  endtask

  task automatic run_phase(input traffic_e mode, input int count);
    int             stop;
    int             pick;
    logic [ScW-1:0] code;
    stop = items_sent + count;
    while (items_sent < stop) begin
      pick = $urandom_range(0, 99);
      code = 8'($urandom);
      case (mode)
        TrafficMix: begin
          if (pick < 30) type_word();
          else if (pick < 55) issue(OpRead, code);
          else if (pick < 70) issue(OpScan, code & ~ScRelBit);
          else if (pick < 80) issue(OpScan, code | ScRelBit);
          else issue(OpScan, code);
        end
        TrafficFill: begin
          if (pick < 80) begin
            issue(OpScan, pick_key());
          end else if (pick < 88) begin
            code = (code[0]) ? ScLshift : ScRshift;
            issue(OpScan, ($urandom_range(0, 1) != 0) ? (code | ScRelBit) : code);
          end else if (pick < 95) begin
            type_word();
          end else begin
            issue(OpScan, code);
          end
        end
        default: begin
          if (pick < 80) issue(OpRead, code);
          else if (pick < 92) issue(OpScan, pick_key());
          else type_word();
        end
      endcase
    end
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    req_if.valid = 1'b0;
    req_if.op = OpScan;
    req_if.scancode = '0;
    req_up = 1'b0;
    items_sent = 0;
    burst_left = $urandom_range(1, 12);
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    issue(OpRead, 8'hFF);
    issue(OpScan, 8'h00);
    issue(OpScan, 8'h7F);
    issue(OpScan, 8'hFF);
    issue(OpScan, ScRelBit);
    issue(OpScan, ScBackspace);
    issue(OpScan, ScEnter);
    issue(OpScan, ScSpace);
    issue(OpScan, 8'h1E);
    issue(OpScan, ScLshift);
    issue(OpScan, 8'h1E);
    issue(OpScan, ScBackspace);
    issue(OpScan, ScEnter);
    issue(OpScan, ScSpace);
    issue(OpScan, 8'h35);
    issue(OpScan, ScLshift | ScRelBit);
    issue(OpScan, ScRshift);
    issue(OpScan, ScPipe);
    issue(OpScan, ScRshift | ScRelBit);
    issue(OpScan, ScPipe);
    repeat (5) issue(OpRead, 8'h00);

    run_phase(TrafficMix, 50);
    run_phase(TrafficFill, 380);
    run_phase(TrafficDrain, 280);
    run_phase(TrafficMix, 40);

    if (req_up) begin
      req_if.valid <= 1'b0;
      req_up = 1'b0;
    end
    while (sb.expected_rsp.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("scancode_to_ascii_fifo test passed");
    end else begin
      $display("scancode_to_ascii_fifo test failed");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("scancode_to_ascii_fifo test failed");
    $finish;
  end

endmodule

@@ files.f @@
src/scaf_pkg.sv
src/scaf_if.sv
src/scaf_ctrl.sv
src/scaf_dp.sv
src/scancode_to_ascii_fifo.sv
tb/scancode_to_ascii_fifo_tb.sv
